// ===== hdl/alist_pkg.sv =====
// ----------------------------------------------------------------------------
// alist_pkg
// Shared types and codes for the array list engine: operation codes, result
// status codes, controller states and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package alist_pkg;

   localparam int unsigned POSITION_W = 6;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned INDEX_W    = 5;
   localparam int unsigned COUNT_W    = 6;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_FIND   = 2'd1,
      OP_INSERT = 2'd2,
      OP_DELETE = 2'd3
   } alist_op_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_BADPOS   = 2'd2,
      STATUS_NOTFOUND = 2'd3
   } alist_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_INS,
      ST_DEL,
      ST_DONE
   } alist_state_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [INDEX_W-1:0] found_index;
      alist_status_type   status;
   } alist_result_type;

endpackage

`default_nettype wire

// ===== hdl/alist_ram.sv =====
// ----------------------------------------------------------------------------
// alist_ram
// Element store: one write port and one read port, read data registered.
// Contents are not cleared by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module alist_ram #(
   parameter int unsigned DEPTH = 32,
   parameter int unsigned AW    = 5
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [31:0]   wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [31:0]   rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/alist_ctrl.sv =====
// ----------------------------------------------------------------------------
// alist_ctrl
// Operation sequencer: keeps the element count, scans the store for find and
// moves entries one per cycle for insert and delete, each read in the cycle
// before the write that uses the data.
// ----------------------------------------------------------------------------
`default_nettype none

module alist_ctrl #(
   parameter int unsigned CAPACITY = 32,
   parameter int unsigned AW       = 5,
   parameter int unsigned CW       = 6
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request side
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire alist_pkg::alist_op_type   req_op,
   input  wire logic [5:0]                req_position,
   input  wire logic signed [31:0]        req_value,
   // result side
   output logic                           res_valid,
   input  wire logic                      res_ready,
   output alist_pkg::alist_result_type    res_data,
   // store access
   output logic                           mem_wr_en,
   output logic [AW-1:0]                  mem_wr_addr,
   output logic [31:0]                    mem_wr_data,
   output logic                           mem_rd_en,
   output logic [AW-1:0]                  mem_rd_addr,
   input  wire logic [31:0]               mem_rd_data
);

   localparam int unsigned CMPW = ((CW > 6) ? CW : 6) + 1;

   alist_pkg::alist_state_type  state_ff, state_in;
   alist_pkg::alist_status_type status_ff, status_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               ptr_ff, ptr_in;
   logic [CW-1:0]               pos_ff, pos_in;
   logic [CW-1:0]               pend_addr_ff, pend_addr_in;
   logic                        pend_ff, pend_in;
   logic [4:0]                  fidx_ff, fidx_in;
   logic [31:0]                 val_ff, val_in;

   logic [CMPW-1:0] n_wide;
   logic [CMPW-1:0] pos_wide;
   logic [CW-1:0]   ptr_m1;
   logic [CW-1:0]   ptr_p1;
   logic [CW-1:0]   pos_m1;
   logic [31:0]     pend_addr_ext;
   logic [31:0]     count_ext;

   assign n_wide        = CMPW'(count_ff);
   assign pos_wide      = CMPW'(req_position);
   assign ptr_m1        = ptr_ff - CW'(1);
   assign ptr_p1        = ptr_ff + CW'(1);
   assign pos_m1        = pos_ff - CW'(1);
   assign pend_addr_ext = 32'(pend_addr_ff);
   assign count_ext     = 32'(count_ff);

   assign res_data.status      = status_ff;
   assign res_data.found_index = fidx_ff;
   assign res_data.count       = count_ext[5:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= alist_pkg::ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      ptr_ff       <= ptr_in;
      pos_ff       <= pos_in;
      pend_addr_ff <= pend_addr_in;
      fidx_ff      <= fidx_in;
      val_ff       <= val_in;
   end

   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      pos_in       = pos_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      fidx_in      = fidx_ff;
      val_in       = val_ff;
      req_ready    = 1'b0;
      res_valid    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = ptr_ff[AW-1:0];
      mem_wr_data  = val_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = ptr_ff[AW-1:0];

      unique case (state_ff)
         alist_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               fidx_in   = '0;
               val_in    = req_value;
               pos_in    = CW'(req_position);
               status_in = alist_pkg::STATUS_OK;
               state_in  = alist_pkg::ST_DONE;
               unique case (req_op)
                  alist_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  alist_pkg::OP_FIND: begin
                     status_in = alist_pkg::STATUS_NOTFOUND;
                     ptr_in    = '0;
                     if (count_ff != '0) begin
                        state_in = alist_pkg::ST_FIND;
                     end
                  end
                  alist_pkg::OP_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        status_in = alist_pkg::STATUS_FULL;
                     end else if (pos_wide == '0 || pos_wide > n_wide + CMPW'(1)) begin
                        status_in = alist_pkg::STATUS_BADPOS;
                     end else begin
                        ptr_in   = count_ff;
                        state_in = alist_pkg::ST_INS;
                     end
                  end
                  alist_pkg::OP_DELETE: begin
                     if (pos_wide == '0 || pos_wide > n_wide) begin
                        status_in = alist_pkg::STATUS_BADPOS;
                     end else begin
                        ptr_in   = CW'(req_position);
                        state_in = alist_pkg::ST_DEL;
                     end
                  end
               endcase
            end
         end

         alist_pkg::ST_FIND: begin
            // read one entry ahead of the compare
            if (ptr_ff < count_ff) begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = ptr_ff[AW-1:0];
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff;
               ptr_in       = ptr_p1;
            end
            if (pend_ff && mem_rd_data == val_ff) begin
               status_in = alist_pkg::STATUS_OK;
               fidx_in   = pend_addr_ext[4:0];
               pend_in   = 1'b0;
               state_in  = alist_pkg::ST_DONE;
            end else if (pend_ff && ptr_ff == count_ff) begin
               pend_in  = 1'b0;
               state_in = alist_pkg::ST_DONE;
            end
         end

         alist_pkg::ST_INS: begin
            // ptr is the destination slot; its source is the slot below
            if (ptr_ff >= pos_ff) begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = ptr_m1[AW-1:0];
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff;
               ptr_in       = ptr_m1;
            end
            if (pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = pend_addr_ff[AW-1:0];
               mem_wr_data = mem_rd_data;
            end else if (ptr_ff < pos_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = pos_m1[AW-1:0];
               mem_wr_data = val_ff;
               count_in    = count_ff + CW'(1);
               state_in    = alist_pkg::ST_DONE;
            end
         end

         alist_pkg::ST_DEL: begin
            // ptr is the source slot; its data moves one slot down
            if (ptr_ff < count_ff) begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = ptr_ff[AW-1:0];
               pend_in      = 1'b1;
               pend_addr_in = ptr_m1;
               ptr_in       = ptr_p1;
            end
            if (pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = pend_addr_ff[AW-1:0];
               mem_wr_data = mem_rd_data;
            end else if (ptr_ff >= count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = alist_pkg::ST_DONE;
            end
         end

         alist_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = alist_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = alist_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/array_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// array_list_engine_top
// Fixed-capacity ordered list with clear, find, insert and delete requests.
// Requests: one at a time; a new request is taken only after the result of
//   the last one has been loaded into the output register.
// Throughput: set by the scan/shift loop, which handles one entry per cycle.
// Reset: the element count clears to zero (empty list); the store itself is
//   not cleared, entries are only read after they are written.
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_engine_top #(
   parameter int unsigned CAPACITY = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] op, [7:2] position, [39:8] value
   input  wire logic [39:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] status, [6:2] found_index, [12:7] count, [15:13] zero
   output logic [15:0]      rsp_tdata
);

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   logic                        res_valid;
   logic                        res_ready;
   alist_pkg::alist_result_type res_data;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [31:0]   mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [31:0]   mem_rd_data;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_data_ff, rsp_data_in;

   alist_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_op       (alist_pkg::alist_op_type'(req_tdata[1:0])),
      .req_position (req_tdata[7:2]),
      .req_value    (signed'(req_tdata[39:8])),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res_data     (res_data),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data)
   );

   alist_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // output register: load when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = {3'b000, res_data.count, res_data.found_index,
                           res_data.status};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== dv/tb_array_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// tb_array_list_engine_top
// Self-checking bench for the array list engine. A behavioral list model
// predicts status, match index and element count for every accepted request.
// Directed, full-list and long random runs are pushed through the request
// stream with bursty timing while the response side stalls on its own
// pattern. Responses are matched in order against the predicted results.
// ----------------------------------------------------------------------------

module tb_array_list_engine_top;
   timeunit 1ns;
   timeprecision 1ps;

   import alist_pkg::*;

   localparam int unsigned LIST_CAPACITY = 32;
   localparam int unsigned RANDOM_ITEMS  = 1480;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // [1:0] op, [7:2] position, [39:8] value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [1:0] status, [6:2] found_index, [12:7] count

   // list model state
   logic [31:0]      list_mem [LIST_CAPACITY];
   int unsigned      list_len = 0;
   alist_result_type pending_q[$];

   int unsigned mismatch_count = 0;
   int unsigned burst_left     = 0;
   int unsigned sink_mode      = 0;
   int unsigned sink_span      = 0;

   array_list_engine_top #(
      .CAPACITY(LIST_CAPACITY)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // apply one request to the list model and return its outcome
   function automatic alist_result_type apply_list_op(input alist_op_type op,
                                                      input logic [5:0] pos,
                                                      input logic [31:0] val);
      alist_result_type res;
      int p;
      p = pos;
      res.status      = STATUS_OK;
      res.found_index = '0;
      case (op)
         OP_CLEAR: begin
            list_len = 0;
         end
         OP_FIND: begin
            res.status = STATUS_NOTFOUND;
            for (int j = 0; j < list_len; j++) begin
               if (list_mem[j] == val) begin
                  res.status      = STATUS_OK;
                  res.found_index = j[INDEX_W-1:0];
                  break;
               end
            end
         end
         OP_INSERT: begin
            if (list_len >= LIST_CAPACITY) begin
               res.status = STATUS_FULL;
            end else if (p < 1 || p > list_len + 1) begin
               res.status = STATUS_BADPOS;
            end else begin
               for (int j = list_len; j >= p; j--) list_mem[j] = list_mem[j-1];
               list_mem[p-1] = val;
               list_len++;
            end
         end
         default: begin
            if (p < 1 || p > list_len) begin
               res.status = STATUS_BADPOS;
            end else begin
               for (int j = p; j < list_len; j++) list_mem[j-1] = list_mem[j];
               list_len--;
            end
         end
      endcase
      res.count = list_len[COUNT_W-1:0];
      return res;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2, 3, 4: return 32'($signed($urandom_range(0, 6)) - 3);
         default: return $urandom;
      endcase
   endfunction

   // call at a rising edge; returns at the edge where the request was taken
   task automatic send_request(input alist_op_type op, input logic [5:0] pos,
                               input logic [31:0] val);
      int unsigned gap;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 45) : $urandom_range(1, 5);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 6);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {val, pos, op};
      do @(posedge clock); while (!req_tready);
      pending_q.push_back(apply_list_op(op, pos, val));
      burst_left--;
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (LIST_CAPACITY + 8) @(posedge clock);
   endtask

   task automatic test_directed();
      send_request(OP_FIND,   6'd0,  32'h0);           // find on empty list
      send_request(OP_DELETE, 6'd1,  32'h0);           // delete on empty list
      send_request(OP_INSERT, 6'd0,  32'h1);           // position zero
      send_request(OP_INSERT, 6'd2,  32'h1);           // past count+1
      send_request(OP_INSERT, 6'd1,  32'h7fff_ffff);
      send_request(OP_INSERT, 6'd2,  32'h8000_0000);
      send_request(OP_INSERT, 6'd1,  32'd5);
      send_request(OP_INSERT, 6'd2,  32'hffff_ffff);
      send_request(OP_INSERT, 6'd4,  32'd5);           // duplicate key
      send_request(OP_FIND,   6'd0,  32'd5);           // first match wins
      send_request(OP_FIND,   6'd63, 32'h8000_0000);   // last entry
      send_request(OP_FIND,   6'd0,  32'hffff_ffff);
      send_request(OP_FIND,   6'd0,  32'h0);           // absent
      send_request(OP_INSERT, 6'd7,  32'h2);
      send_request(OP_INSERT, 6'd63, 32'h2);
      send_request(OP_DELETE, 6'd0,  32'h0);
      send_request(OP_DELETE, 6'd6,  32'h0);
      send_request(OP_DELETE, 6'd1,  32'hffff_ffff);
      send_request(OP_FIND,   6'd0,  32'd5);
      send_request(OP_DELETE, 6'd4,  32'h0);           // last entry
      send_request(OP_DELETE, 6'd2,  32'h0);           // middle entry
      send_request(OP_INSERT, 6'd3,  32'h5555_aaaa);   // append
      send_request(OP_CLEAR,  6'd42, 32'haaaa_5555);
      send_request(OP_FIND,   6'd0,  32'hffff_ffff);
      send_request(OP_DELETE, 6'd32, 32'h0);
      drain_responses();
   endtask

   task automatic test_full_list();
      send_request(OP_CLEAR, 6'd0, 32'h0);
      while (list_len < LIST_CAPACITY)
         send_request(OP_INSERT, 6'($urandom_range(1, list_len + 1)), pick_value());
      // full outranks a bad position
      send_request(OP_INSERT, 6'd0,  32'h1);
      send_request(OP_INSERT, 6'd33, 32'h1);
      send_request(OP_INSERT, 6'd63, 32'h1);
      send_request(OP_FIND,   6'd0,  list_mem[LIST_CAPACITY-1]);
      send_request(OP_DELETE, 6'd33, 32'h0);
      send_request(OP_DELETE, 6'd63, 32'h0);
      send_request(OP_DELETE, 6'd32, 32'h0);
      send_request(OP_INSERT, 6'd32, 32'h8000_0000);
      send_request(OP_FIND,   6'd0,  32'h8000_0000);
      send_request(OP_DELETE, 6'd1,  32'h0);
      drain_responses();
   endtask

   task automatic test_random_mix(input int unsigned n_items);
      int unsigned  trend;
      int unsigned  roll;
      int unsigned  ins_limit;
      int unsigned  pos;
      alist_op_type op;
      logic [31:0]  val;
      trend = 2;
      for (int i = 0; i < n_items; i++) begin
         // swing between growing, shrinking and steady phases
         if (i % 120 == 0) trend = $urandom_range(0, 2);
         ins_limit = (trend == 0) ? 85 : (trend == 1) ? 45 : 65;
         roll = $urandom_range(0, 99);
         if (roll < 2)              op = OP_CLEAR;
         else if (roll < 30)        op = OP_FIND;
         else if (roll < ins_limit) op = OP_INSERT;
         else                       op = OP_DELETE;

         if ($urandom_range(0, 9) == 0)
            pos = $urandom_range(0, 63);
         else if (op == OP_INSERT)
            pos = $urandom_range(1, list_len + 1);
         else if (op == OP_DELETE && list_len > 0)
            pos = $urandom_range(1, list_len);
         else
            pos = $urandom_range(0, 63);

         if (op == OP_FIND && list_len > 0 && $urandom_range(0, 1) == 1)
            val = list_mem[$urandom_range(0, list_len - 1)];
         else
            val = pick_value();

         send_request(op, pos[5:0], val);
      end
      drain_responses();
   endtask

   // response-side backpressure: ready, coin-flip or mostly stalled stretches
   always @(posedge clock) begin
      if (sink_span == 0) begin
         sink_mode = $urandom_range(0, 2);
         sink_span = $urandom_range(8, 80);
      end else begin
         sink_span--;
      end
      case (sink_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 19) == 0);
      endcase
   end

   always @(posedge clock) begin : check_responses
      alist_result_type got;
      alist_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = alist_result_type'(rsp_tdata[12:0]);
         if (pending_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: data=%h", rsp_tdata);
         end else begin
            want = pending_q.pop_front();
            if (got.status !== want.status || got.found_index !== want.found_index ||
                got.count !== want.count || rsp_tdata[15:13] !== 3'b000) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response mismatch: status exp %0d got %0d, index exp %0d got %0d, count exp %0d got %0d, pad %b",
                           want.status, got.status, want.found_index, got.found_index,
                           want.count, got.count, rsp_tdata[15:13]);
            end
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_list();
      test_random_mix(RANDOM_ITEMS);
      if (mismatch_count == 0 && pending_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
